[design/prle_pkg.sv]
package prle_pkg;

    localparam int IDX_W     = 27;
    localparam int COLOR_W   = 16;
    localparam int PAL_DEPTH = 256;
    localparam int PAL_AW    = 8;
    localparam int BYTE_W    = 8;
    localparam int HDR_W     = 32;
    localparam int FLD_W     = 10;
    localparam int LEN_W     = 12;
    localparam int CTR_W     = 16;

    localparam logic [1:0] REQ_PAL   = 2'd0;
    localparam logic [1:0] REQ_FRAME = 2'd1;
    localparam logic [1:0] REQ_DATA  = 2'd2;

    localparam logic [HDR_W-1:0] END_HDR  = 32'h7fff_7fff;
    localparam logic [HDR_W-1:0] HDR_MASK = (32'h200 << 22) | (32'h200 << 12);
    localparam logic [FLD_W-1:0] POS_BIAS = 10'h200;

    // one decoded event heading for the output side
    typedef struct packed {
        logic             emit;
        logic             frame_end;
        logic             out_of_frame;
        logic [IDX_W-1:0] pixel_index;
    } t_prle_ev;

    // palette port request
    typedef struct packed {
        logic               we;
        logic [PAL_AW-1:0]  waddr;
        logic [COLOR_W-1:0] wdata;
        logic               re;
        logic [PAL_AW-1:0]  raddr;
    } t_prle_ram_req;

endpackage

[design/prle_if.sv]
interface prle_in_if import prle_pkg::*; #(
    parameter int DIM_BITS = 10
) ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic [PAL_AW-1:0]        palette_index;
    logic [COLOR_W-1:0]       palette_color;
    logic [DIM_BITS-1:0]      frame_width;
    logic [DIM_BITS-1:0]      frame_height;
    logic signed [CTR_W-1:0]  center_x;
    logic signed [CTR_W-1:0]  center_y;
    logic [BYTE_W-1:0]        data_byte;

    modport source (
        output valid, req_type, palette_index, palette_color, frame_width,
               frame_height, center_x, center_y, data_byte,
        input  ready
    );
    modport sink (
        input  valid, req_type, palette_index, palette_color, frame_width,
               frame_height, center_x, center_y, data_byte,
        output ready
    );
endinterface

interface prle_out_if import prle_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [IDX_W-1:0]  pixel_index;
    logic [COLOR_W-1:0]       pixel_color;
    logic                     out_of_frame;
    logic                     frame_end;

    modport source (
        output valid, pixel_index, pixel_color, out_of_frame, frame_end,
        input  ready
    );
    modport sink (
        input  valid, pixel_index, pixel_color, out_of_frame, frame_end,
        output ready
    );
endinterface

[design/prle_ram.sv]
module prle_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/prle_parse.sv]
module prle_parse import prle_pkg::*; #(
    parameter int MAX_DIM_BITS = 10
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_acc,
    input  logic [1:0]              i_req_type,
    input  logic [PAL_AW-1:0]       i_palette_index,
    input  logic [COLOR_W-1:0]      i_palette_color,
    input  logic [MAX_DIM_BITS-1:0] i_frame_width,
    input  logic [MAX_DIM_BITS-1:0] i_frame_height,
    input  logic signed [CTR_W-1:0] i_center_x,
    input  logic signed [CTR_W-1:0] i_center_y,
    input  logic [BYTE_W-1:0]       i_data_byte,
    output t_prle_ev                o_ev,
    output t_prle_ram_req           o_ram
);

    localparam int AREA_W = 2 * MAX_DIM_BITS;
    localparam int YS_W   = CTR_W + 2;
    localparam int PW     = (YS_W + MAX_DIM_BITS + 1 > IDX_W) ?
                            YS_W + MAX_DIM_BITS + 1 : IDX_W;
    localparam int CW     = (AREA_W > IDX_W) ? AREA_W : IDX_W;
    localparam int YW_W   = FLD_W + MAX_DIM_BITS;

    logic                    r_in_run, n_in_run;
    logic [1:0]              r_cnt, n_cnt;
    logic [23:0]             r_hdr, n_hdr;
    logic [LEN_W-1:0]        r_rem, n_rem;
    logic [IDX_W-1:0]        r_cur, n_cur;
    logic [IDX_W-1:0]        r_base, n_base;
    logic [MAX_DIM_BITS-1:0] r_w, n_w;
    logic [AREA_W-1:0]       r_area, n_area;

    logic                    is_pal, is_frame, is_data;
    logic [HDR_W-1:0]        raw, hdr_x;
    logic [FLD_W-1:0]        xf, yf;
    logic [LEN_W-1:0]        len;
    logic [YS_W-1:0]         y_sum;
    logic [PW-1:0]           y_prod;
    logic [IDX_W-1:0]        x_ofs;
    logic [AREA_W-1:0]       area;
    logic [YW_W-1:0]         yw;
    logic [IDX_W-1:0]        hdr_idx;
    logic                    run_oof;

    assign is_pal   = i_acc && (i_req_type == REQ_PAL);
    assign is_frame = i_acc && (i_req_type == REQ_FRAME);
    assign is_data  = i_acc && (i_req_type == REQ_DATA);

    // frame start: base index from the center, size product for the range check
    assign y_sum  = {{(YS_W-CTR_W){i_center_y[CTR_W-1]}}, i_center_y}
                  + YS_W'(i_frame_height) - YS_W'(POS_BIAS);
    assign y_prod = {{(PW-YS_W){y_sum[YS_W-1]}}, y_sum} * PW'(i_frame_width);
    assign x_ofs  = {{(IDX_W-CTR_W){i_center_x[CTR_W-1]}}, i_center_x}
                  - IDX_W'(POS_BIAS);
    assign area   = AREA_W'(i_frame_width) * AREA_W'(i_frame_height);

    // header: last byte completes the little-endian word
    assign raw     = {i_data_byte, r_hdr};
    assign hdr_x   = raw ^ HDR_MASK;
    assign xf      = hdr_x[31:22];
    assign yf      = hdr_x[21:12];
    assign len     = hdr_x[LEN_W-1:0];
    assign yw      = YW_W'(yf) * YW_W'(r_w);
    assign hdr_idx = r_base + IDX_W'(yw) + IDX_W'(xf);

    assign run_oof = r_cur[IDX_W-1] || (CW'(r_cur) >= CW'(r_area));

    always_comb begin
        n_in_run = r_in_run;
        n_cnt    = r_cnt;
        n_hdr    = r_hdr;
        n_rem    = r_rem;
        n_cur    = r_cur;
        n_base   = r_base;
        n_w      = r_w;
        n_area   = r_area;
        o_ev     = '0;

        if (is_frame) begin
            n_w      = i_frame_width;
            n_area   = area;
            n_base   = x_ofs + y_prod[IDX_W-1:0];
            n_in_run = 1'b0;
            n_cnt    = 2'd0;
            n_hdr    = '0;
            n_rem    = '0;
            n_cur    = '0;
        end else if (is_data) begin
            if (r_in_run) begin
                o_ev.emit         = 1'b1;
                o_ev.out_of_frame = run_oof;
                o_ev.pixel_index  = r_cur;
                n_cur    = r_cur + IDX_W'(1);
                n_rem    = r_rem - LEN_W'(1);
                n_in_run = (r_rem != LEN_W'(1));
            end else if (r_cnt != 2'd3) begin
                unique case (r_cnt)
                    2'd0:    n_hdr[7:0]   = i_data_byte;
                    2'd1:    n_hdr[15:8]  = i_data_byte;
                    default: n_hdr[23:16] = i_data_byte;
                endcase
                n_cnt = r_cnt + 2'd1;
            end else begin
                n_cnt = 2'd0;
                n_hdr = '0;
                if (raw == END_HDR) begin
                    o_ev.emit      = 1'b1;
                    o_ev.frame_end = 1'b1;
                end else begin
                    n_cur    = hdr_idx;
                    n_rem    = len;
                    n_in_run = (len != '0);
                end
            end
        end
    end

    always_comb begin
        o_ram.we    = is_pal;
        o_ram.waddr = i_palette_index;
        o_ram.wdata = i_palette_color;
        o_ram.re    = is_data && r_in_run;
        o_ram.raddr = i_data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_run <= 1'b0;
            r_cnt    <= 2'd0;
            r_hdr    <= '0;
            r_rem    <= '0;
            r_cur    <= '0;
            r_base   <= '0;
            r_w      <= '0;
            r_area   <= '0;
        end else begin
            r_in_run <= n_in_run;
            r_cnt    <= n_cnt;
            r_hdr    <= n_hdr;
            r_rem    <= n_rem;
            r_cur    <= n_cur;
            r_base   <= n_base;
            r_w      <= n_w;
            r_area   <= n_area;
        end
    end

    a_run_has_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_run |-> (r_rem != '0))
        else $error("run active with no pixels left");

    a_end_restarts_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ev.emit && o_ev.frame_end) |=> (r_cnt == 2'd0) && !r_in_run)
        else $error("header assembly not restarted after end marker");

    a_read_only_for_pixels: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram.re |-> (o_ev.emit && !o_ev.frame_end && !o_ram.we))
        else $error("palette read without a pixel result");

endmodule

[design/prle_out.sv]
module prle_out import prle_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_prle_ev           i_ev,
    input  logic [COLOR_W-1:0] i_rdata,
    input  logic               i_o_ready,
    output logic               o_in_ready,
    output logic               o_valid,
    output logic [IDX_W-1:0]   o_pixel_index,
    output logic [COLOR_W-1:0] o_pixel_color,
    output logic               o_out_of_frame,
    output logic               o_frame_end
);

    logic               r_s1_vld;
    t_prle_ev           r_s1;
    logic               r_o_vld;
    logic [IDX_W-1:0]   r_o_idx;
    logic [COLOR_W-1:0] r_o_color;
    logic               r_o_oof;
    logic               r_o_end;
    logic               adv;

    // palette data is valid while the stage holds, the read port only fires on accept
    assign adv        = r_s1_vld && (!r_o_vld || i_o_ready);
    assign o_in_ready = !r_s1_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_o_vld  <= 1'b0;
        end else begin
            if (i_ev.emit) begin
                r_s1_vld <= 1'b1;
            end else if (adv) begin
                r_s1_vld <= 1'b0;
            end
            if (adv) begin
                r_o_vld <= 1'b1;
            end else if (i_o_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ev.emit) begin
            r_s1 <= i_ev;
        end
        if (adv) begin
            r_o_idx   <= r_s1.pixel_index;
            r_o_color <= r_s1.frame_end ? '0 : i_rdata;
            r_o_oof   <= r_s1.out_of_frame;
            r_o_end   <= r_s1.frame_end;
        end
    end

    assign o_valid        = r_o_vld;
    assign o_pixel_index  = r_o_idx;
    assign o_pixel_color  = r_o_color;
    assign o_out_of_frame = r_o_oof;
    assign o_frame_end    = r_o_end;

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !adv) |-> !i_ev.emit)
        else $error("new result while the held stage is stalled");

    a_end_marker_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && r_o_end) |-> (r_o_color == '0) && (r_o_idx == '0) && !r_o_oof)
        else $error("end marker carries pixel data");

    a_hold_while_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_vld && !i_o_ready) |=> r_o_vld && $stable(r_o_idx) && $stable(r_o_color)
                                    && $stable(r_o_end))
        else $error("result changed while the receiver stalls");

endmodule

[design/palettized_rle_frame_decoder_top.sv]
// palettized run-length frame decoder
// i_req carries one request per cycle: palette write, frame start or one stream
// byte. palette writes load the 256 x 16 color table, frame start latches the
// size and works out the base index from the image center, stream bytes build
// 4-byte run headers and then pay out one pixel per byte.
// o_pix carries pixel results (index, color, out-of-frame flag) and the end
// marker produced by the end-of-frame header.
// a pixel or end marker passes the palette read stage and then the output
// register on its way to o_pix.
// throughput: one request per cycle while o_pix is not stalled, set by the single
// palette read port and the combinational header index multiply.
// reset clears the stream and frame state (width zero, no run open); palette
// contents are unknown until written.
// if o_pix stalls, one result waits in the output register and one in the read
// stage; i_req.ready is low during reset and otherwise drops only while both are
// held and the output is not taken.
module palettized_rle_frame_decoder_top import prle_pkg::*; #(
    parameter int MAX_DIM_BITS = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    prle_in_if.sink        i_req,
    prle_out_if.source     o_pix
);

    t_prle_ev           ev;
    t_prle_ram_req      ram_req;
    logic [COLOR_W-1:0] ram_rdata;
    logic               in_ready;
    logic               acc;
    logic [IDX_W-1:0]   pix_idx;

    assign acc         = i_req.valid && in_ready && i_rst_n;
    assign i_req.ready = in_ready && i_rst_n;

    prle_parse #(
        .MAX_DIM_BITS(MAX_DIM_BITS)
    ) u_parse (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_acc           (acc),
        .i_req_type      (i_req.req_type),
        .i_palette_index (i_req.palette_index),
        .i_palette_color (i_req.palette_color),
        .i_frame_width   (i_req.frame_width),
        .i_frame_height  (i_req.frame_height),
        .i_center_x      (i_req.center_x),
        .i_center_y      (i_req.center_y),
        .i_data_byte     (i_req.data_byte),
        .o_ev            (ev),
        .o_ram           (ram_req)
    );

    prle_ram #(
        .WIDTH(COLOR_W),
        .DEPTH(PAL_DEPTH)
    ) u_palette (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    prle_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ev           (ev),
        .i_rdata        (ram_rdata),
        .i_o_ready      (o_pix.ready),
        .o_in_ready     (in_ready),
        .o_valid        (o_pix.valid),
        .o_pixel_index  (pix_idx),
        .o_pixel_color  (o_pix.pixel_color),
        .o_out_of_frame (o_pix.out_of_frame),
        .o_frame_end    (o_pix.frame_end)
    );

    assign o_pix.pixel_index = $signed(pix_idx);

endmodule

[verif/tb_palettized_rle_frame_decoder_top.sv]
`timescale 1ns / 1ps

module tb_palettized_rle_frame_decoder_top;
    import prle_pkg::*;

    localparam int DIM          = 10;
    localparam int RANDOM_REQS  = 1850;
    localparam int STALL_LIMIT  = 2000;
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]              kind;
        logic [PAL_AW-1:0]       pal_addr;
        logic [COLOR_W-1:0]      pal_color;
        logic [DIM-1:0]          width;
        logic [DIM-1:0]          height;
        logic signed [CTR_W-1:0] cx;
        logic signed [CTR_W-1:0] cy;
        logic [BYTE_W-1:0]       octet;
    } t_req;

    typedef struct {
        logic signed [IDX_W-1:0] index;
        logic [COLOR_W-1:0]      color;
        logic                    off_frame;
        logic                    last;
    } t_pix;

    typedef struct {
        t_req rq;
        bit   fixed;
        t_pix want;
    } t_row;

    logic i_clk;
    logic i_rst_n = 1'b0;
    logic sink_rdy = 1'b0;

    prle_in_if #(.DIM_BITS(DIM)) req_if ();
    prle_out_if pix_if ();

    assign pix_if.ready = sink_rdy;

    palettized_rle_frame_decoder_top #(.MAX_DIM_BITS(DIM)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_pix   (pix_if.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // decoder mirror
    logic [COLOR_W-1:0] pal_mem [PAL_DEPTH];
    bit                 pal_set [PAL_DEPTH];
    bit                 run_open;
    logic [1:0]         hdr_cnt;
    logic [HDR_W-1:0]   hdr_acc;
    logic [LEN_W-1:0]   run_left;
    logic [IDX_W-1:0]   pix_pos;
    logic [IDX_W-1:0]   frame_base;
    logic [DIM-1:0]     fr_w;
    logic [DIM-1:0]     fr_h;

    t_pix pix_due [$];
    t_pix no_pix;
    t_row dir_rows [$];

    int  n_reqs, n_frames, n_pixels, n_off, n_ends, n_err;
    bit  src_fast;
    int  sink_hold, sink_burst;
    int  idle_cycles;

    function automatic bit decode_step(input t_req rq, output t_pix px);
        longint base, pos, area;
        logic [HDR_W-1:0] hw;
        logic [FLD_W-1:0] xf, yf;
        px.index = '0;
        px.color = '0;
        px.off_frame = 1'b0;
        px.last = 1'b0;
        decode_step = 1'b0;
        case (rq.kind)
            REQ_PAL: begin
                pal_mem[rq.pal_addr] = rq.pal_color;
                pal_set[rq.pal_addr] = 1'b1;
            end
            REQ_FRAME: begin
                fr_w = rq.width;
                fr_h = rq.height;
                base = (longint'(rq.cx) - longint'(POS_BIAS))
                     + (longint'(rq.cy) + longint'(fr_h) - longint'(POS_BIAS)) * longint'(fr_w);
                frame_base = base[IDX_W-1:0];
                run_open = 1'b0;
                hdr_cnt = '0;
                hdr_acc = '0;
                run_left = '0;
                pix_pos = '0;
                n_frames++;
            end
            REQ_DATA: begin
                if (run_open) begin
                    pos = longint'($signed(pix_pos));
                    area = longint'(fr_w) * longint'(fr_h);
                    px.index = pix_pos;
                    px.color = pal_mem[rq.octet];
                    px.off_frame = (pos < 0) || (pos >= area);
                    pix_pos = pix_pos + IDX_W'(1);
                    run_left = run_left - LEN_W'(1);
                    if (run_left == '0)
                        run_open = 1'b0;
                    decode_step = 1'b1;
                    n_pixels++;
                    if (px.off_frame)
                        n_off++;
                end else begin
                    hdr_acc = hdr_acc | (HDR_W'(rq.octet) << (8 * hdr_cnt));
                    if (hdr_cnt != 2'd3) begin
                        hdr_cnt++;
                    end else begin
                        hw = hdr_acc;
                        hdr_cnt = '0;
                        hdr_acc = '0;
                        if (hw == END_HDR) begin
                            px.last = 1'b1;
                            decode_step = 1'b1;
                            n_ends++;
                        end else begin
                            hw = hw ^ HDR_MASK;
                            xf = hw[31:22];
                            yf = hw[21:12];
                            run_left = hw[LEN_W-1:0];
                            pix_pos = frame_base + IDX_W'(yf) * IDX_W'(fr_w) + IDX_W'(xf);
                            run_open = (run_left != '0);
                        end
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_req rand_req(input logic [1:0] kind);
        t_req rq;
        rq.kind = kind;
        rq.pal_addr = PAL_AW'($urandom);
        rq.pal_color = COLOR_W'($urandom);
        rq.width = DIM'($urandom);
        rq.height = DIM'($urandom);
        rq.cx = CTR_W'($urandom);
        rq.cy = CTR_W'($urandom);
        rq.octet = BYTE_W'($urandom);
        return rq;
    endfunction

    function automatic t_req mk_pal(input logic [PAL_AW-1:0] a, input logic [COLOR_W-1:0] c);
        t_req rq;
        rq = rand_req(REQ_PAL);
        rq.pal_addr = a;
        rq.pal_color = c;
        return rq;
    endfunction

    function automatic t_req mk_byte(input logic [BYTE_W-1:0] b);
        t_req rq;
        rq = rand_req(REQ_DATA);
        rq.octet = b;
        return rq;
    endfunction

    // keeps stray headers short: length bits 11..8 cleared
    function automatic logic [BYTE_W-1:0] noise_byte();
        logic [BYTE_W-1:0] b;
        b = BYTE_W'($urandom);
        if (!run_open && hdr_cnt == 2'd1)
            b[3:0] = 4'h0;
        return b;
    endfunction

    function automatic int dim_pick();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 17)
            return $urandom_range(0, 15);
        if (pick < 19)
            return $urandom_range(0, 1023);
        return 1023 * $urandom_range(0, 1);
    endfunction

    task automatic add_row(input t_req rq);
        t_row r;
        r.rq = rq;
        r.fixed = 1'b0;
        r.want = no_pix;
        dir_rows = {dir_rows, r};
    endtask

    task automatic add_ref(input t_req rq, input logic signed [IDX_W-1:0] idx,
                           input logic [COLOR_W-1:0] col, input logic oof, input logic fend);
        t_row r;
        r.rq = rq;
        r.fixed = 1'b1;
        r.want.index = idx;
        r.want.color = col;
        r.want.off_frame = oof;
        r.want.last = fend;
        dir_rows = {dir_rows, r};
    endtask

    task automatic send_req(input t_req rq_in, input bit fixed, input t_pix want);
        t_req rq;
        t_pix got;
        int gap;
        int k;
        rq = rq_in;
        // pixel bytes only ever index palette entries that were loaded
        if (rq.kind == REQ_DATA && run_open && !pal_set[rq.octet]) begin
            do k = $urandom_range(0, PAL_DEPTH - 1); while (!pal_set[k]);
            rq.octet = k[PAL_AW-1:0];
        end
        gap = src_fast ? 0 : $urandom_range(0, 11);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.req_type <= rq.kind;
        req_if.palette_index <= rq.pal_addr;
        req_if.palette_color <= rq.pal_color;
        req_if.frame_width <= rq.width;
        req_if.frame_height <= rq.height;
        req_if.center_x <= rq.cx;
        req_if.center_y <= rq.cy;
        req_if.data_byte <= rq.octet;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        if (decode_step(rq, got))
            pix_due = {pix_due, (fixed ? want : got)};
        if (rq.kind != REQ_UNUSED)
            n_reqs++;
    endtask

    task automatic send_item(input t_req rq);
        send_req(rq, 1'b0, no_pix);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        send_item(mk_byte(b));
    endtask

    // finish any open run or partial header, then send one 32-bit header
    task automatic send_word(input logic [HDR_W-1:0] raw);
        while (run_open || hdr_cnt != 2'd0)
            send_byte(noise_byte());
        for (int k = 0; k < 4; k++)
            send_byte(raw[8*k +: 8]);
    endtask

    task automatic wait_results();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (pix_due.size() != 0);
    endtask

    task automatic frame_episode();
        t_req rq;
        int w, h, n_runs, xf, yf, len, pick;
        src_fast = ($urandom_range(0, 3) == 0);
        w = int'(fr_w);
        h = int'(fr_h);
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 8))
                send_item(mk_pal(PAL_AW'($urandom), COLOR_W'($urandom)));
        if ($urandom_range(0, 4) != 0) begin
            w = dim_pick();
            h = dim_pick();
            rq = rand_req(REQ_FRAME);
            rq.width = DIM'(w);
            rq.height = DIM'(h);
            // mostly centered so that headers land inside the frame
            if ($urandom_range(0, 9) < 7) begin
                rq.cx = CTR_W'(int'(POS_BIAS) + int'($urandom_range(0, 4)) - 2);
                rq.cy = CTR_W'(int'(POS_BIAS) - h + int'($urandom_range(0, 4)) - 2);
            end
            send_item(rq);
        end
        n_runs = $urandom_range(0, 6);
        repeat (n_runs) begin
            xf = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, w + 1);
            yf = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, h + 1);
            pick = $urandom_range(0, 19);
            if (pick < 2)
                len = 0;
            else if (pick < 16)
                len = $urandom_range(1, 6);
            else if (pick < 19)
                len = $urandom_range(7, 40);
            else
                len = $urandom_range(41, 200);
            send_word({xf[9:0], yf[9:0], len[11:0]} ^ HDR_MASK);
            while (run_open) begin
                if ($urandom_range(0, 19) == 0)
                    send_item(mk_pal(PAL_AW'($urandom), COLOR_W'($urandom)));
                send_byte(BYTE_W'($urandom));
            end
        end
        if ($urandom_range(0, 5) == 0) begin
            repeat ($urandom_range(1, 5)) begin
                pick = $urandom_range(0, 9);
                if (pick == 0)
                    send_item(rand_req(REQ_UNUSED));
                else if (pick == 1)
                    send_item(rand_req(REQ_FRAME));
                else
                    send_byte(noise_byte());
            end
        end
        if ($urandom_range(0, 9) < 6)
            send_word(END_HDR);
    endtask

    // result side: random stalls, with stretches of no stall
    always @(posedge i_clk) begin
        int n;
        if (!i_rst_n) begin
            sink_rdy <= 1'b0;
            sink_hold = 1;
            sink_burst = 0;
        end else if (pix_if.valid === 1'b1 && sink_rdy) begin
            if (sink_burst > 0) begin
                n = 0;
                sink_burst--;
            end else begin
                n = $urandom_range(0, 11);
                if ($urandom_range(0, 24) == 0)
                    sink_burst = $urandom_range(16, 64);
            end
            if (n == 0) begin
                sink_rdy <= 1'b1;
            end else begin
                sink_rdy <= 1'b0;
                sink_hold = n;
            end
        end else if (!sink_rdy) begin
            if (sink_hold <= 1)
                sink_rdy <= 1'b1;
            else
                sink_hold--;
        end
    end

    always @(posedge i_clk) begin
        t_pix want;
        bit bad;
        if (i_rst_n && pix_if.valid === 1'b1 && sink_rdy) begin
            if (pix_due.size() == 0) begin
                $display("%0t: result with none pending: index %0d color %0h oof %0b end %0b",
                         $time, pix_if.pixel_index, pix_if.pixel_color, pix_if.out_of_frame,
                         pix_if.frame_end);
                n_err++;
            end else begin
                want = pix_due.pop_front();
                bad = 1'b0;
                if (pix_if.pixel_index !== want.index) begin
                    $display("%0t: pixel_index expected %0d got %0d",
                             $time, want.index, pix_if.pixel_index);
                    bad = 1'b1;
                end
                if (pix_if.pixel_color !== want.color) begin
                    $display("%0t: pixel_color expected %0h got %0h",
                             $time, want.color, pix_if.pixel_color);
                    bad = 1'b1;
                end
                if (pix_if.out_of_frame !== want.off_frame) begin
                    $display("%0t: out_of_frame expected %0b got %0b",
                             $time, want.off_frame, pix_if.out_of_frame);
                    bad = 1'b1;
                end
                if (pix_if.frame_end !== want.last) begin
                    $display("%0t: frame_end expected %0b got %0b",
                             $time, want.last, pix_if.frame_end);
                    bad = 1'b1;
                end
                if (bad)
                    n_err++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (pix_if.valid === 1'b1 && sink_rdy))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results pending",
                     $time, idle_cycles, pix_due.size());
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        int goal;
        bit paused;
        req_if.valid <= 1'b0;
        req_if.req_type <= REQ_PAL;
        req_if.palette_index <= '0;
        req_if.palette_color <= '0;
        req_if.frame_width <= '0;
        req_if.frame_height <= '0;
        req_if.center_x <= '0;
        req_if.center_y <= '0;
        req_if.data_byte <= '0;
        no_pix = '{default: '0};
        run_open = 1'b0;
        hdr_cnt = '0;
        hdr_acc = '0;
        run_left = '0;
        pix_pos = '0;
        frame_base = '0;
        fr_w = '0;
        fr_h = '0;
        idle_cycles = 0;
        src_fast = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        add_row(mk_pal(8'hff, 16'hffff));
        add_row(mk_pal(8'h00, 16'h0000));
        add_row(rand_req(REQ_UNUSED));
        // end header before any frame start
        add_row(mk_byte(8'hff));
        add_row(mk_byte(8'h7f));
        add_row(mk_byte(8'hff));
        add_ref(mk_byte(8'h7f), '0, 16'h0000, 1'b0, 1'b1);
        // x = y = 0, length 2 against zero width: both pixels off the frame
        add_row(mk_byte(8'h02));
        add_row(mk_byte(8'h00));
        add_row(mk_byte(8'h20));
        add_row(mk_byte(8'h80));
        add_ref(mk_byte(8'hff), '0, 16'hffff, 1'b1, 1'b0);
        add_ref(mk_byte(8'h00), IDX_W'(1), 16'h0000, 1'b1, 1'b0);
        // largest frame, center at the extremes
        add_row('{REQ_FRAME, 8'h5a, 16'ha5a5, 10'h3ff, 10'h3ff, 16'sh8000, 16'sh7fff, 8'h3c});
        // zero-length run
        add_row(mk_byte(8'h00));
        add_row(mk_byte(8'h00));
        add_row(mk_byte(8'h20));
        add_row(mk_byte(8'h80));
        // x = y = 0x3ff, length 1
        add_row(mk_byte(8'h01));
        add_row(mk_byte(8'hf0));
        add_row(mk_byte(8'hdf));
        add_row(mk_byte(8'h7f));
        add_row(mk_byte(8'hff));
        foreach (dir_rows[i])
            send_req(dir_rows[i].rq, dir_rows[i].fixed, dir_rows[i].want);

        goal = n_reqs + RANDOM_REQS;
        paused = 1'b0;
        while (n_reqs < goal) begin
            frame_episode();
            if ((!paused && n_reqs >= goal - RANDOM_REQS / 2) || $urandom_range(0, 29) == 0) begin
                wait_results();
                paused = 1'b1;
            end
        end
        wait_results();
        repeat (8) @(posedge i_clk);

        $display("covered %0d requests over %0d frame starts", n_reqs, n_frames);
        $display("checked %0d pixels (%0d off the frame) and %0d end markers",
                 n_pixels, n_off, n_ends);
        if (n_err == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
